// ===== src/dwps_pkg.sv =====
`default_nettype none

package dwps_pkg;

	// item kinds
	localparam logic [1:0] KIND_NOTCH = 2'd0;
	localparam logic [1:0] KIND_STALL = 2'd1;
	localparam logic [1:0] KIND_PID   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NOTCH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd4;

	// register reset values
	localparam logic [7:0]  TARGET_RST = 8'd36;
	localparam logic [15:0] NOTCH_RST  = 16'd10525;
	localparam logic [15:0] GAIN_P_RST = 16'd26;
	localparam logic [15:0] GAIN_I_RST = 16'd2560;
	localparam logic [15:0] GAIN_D_RST = 16'd256;

	// datapath widths
	localparam int TIME_W  = 32;
	localparam int SPEED_W = 16;
	localparam int NUM_W   = 27;  // notch distance times 1600
	localparam int GAIN_W  = 16;
	localparam int ERR_W   = 18;
	localparam int SUM_W   = 32;
	localparam int ACC_W   = 50;
	localparam int LVL_SH  = 12;

	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

	typedef struct packed {
		logic [1:0]        kind;
		logic              wheel;
		logic [TIME_W-1:0] timestamp_us;
	} in_item_t;

	typedef struct packed {
		logic               out_wheel;
		logic [15:0]        drive_level;
		logic [SPEED_W-1:0] measured_speed;
		logic               last;
	} out_item_t;

	// operands of one pid product sum
	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [ERR_W-1:0]  err;
		logic [SUM_W-1:0]  esum;
		logic [ERR_W-1:0]  derr;
	} mac_op_t;

endpackage

`default_nettype wire

// ===== src/dual_wheel_encoder_pid_speed.sv =====
`default_nettype none

// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    in_item_t (kind, wheel, timestamp_us)
// result    out        result_valid / result_stall out_item_t (wheel, level, speed, last)
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// a first notch and a stall tick finish in ST_IDLE; a later notch waits in ST_DIV for
// the bit-serial divider (27 quotient bits, one per cycle)
// a pid tick runs ST_PID, ST_MAC and ST_OUT per wheel; ST_MAC waits for the 16-step shift-add multiplier
// item_stall is high while an item is in work; a pending result does not block intake
// a stalled result holds in the output register and the next wheel waits for it
// reset restores the register defaults and clears all per-wheel state

module dual_wheel_encoder_pid_speed import dwps_pkg::*; #(
	parameter int NUM_WHEELS = 2
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire in_item_t              item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output out_item_t                  result,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WW      = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
	localparam int NUM_OUT = (NUM_WHEELS < 2) ? NUM_WHEELS : 2;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_PID  = 5'b00100,
		ST_MAC  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t state_q;

	logic [7:0]        target_q;
	logic [15:0]       notch_q;
	logic [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;

	logic [TIME_W-1:0]  prev_time_q [NUM_WHEELS];
	logic               seen_q      [NUM_WHEELS];
	logic               moved_q     [NUM_WHEELS];
	logic [SPEED_W-1:0] speed_q     [NUM_WHEELS];
	logic [SUM_W-1:0]   esum_q      [NUM_WHEELS];
	logic [ERR_W-1:0]   perr_q      [NUM_WHEELS];

	logic [WW-1:0] wsel_q;
	logic          k_q;
	logic [15:0]   lvl_q;
	logic          result_valid_q;
	out_item_t     result_q;

	logic               item_take;
	logic [WW-1:0]      item_idx;
	logic               wheel_ok;
	logic [TIME_W-1:0]  interval;
	logic [NUM_W-1:0]   notch_num;
	logic               div_start;
	logic               div_done;
	logic [NUM_W-1:0]   div_quo;
	logic [SPEED_W-1:0] quo_sat;

	logic [WW-1:0]      pidx;
	logic [ERR_W-1:0]   err;
	logic [SUM_W+1:0]   sum_wide;
	logic [SUM_W-1:0]   sum_sat;
	logic [ERR_W-1:0]   derr;
	logic               mac_start;
	mac_op_t            mac_op;
	logic               mac_done;
	logic [ACC_W-1:0]   mac_acc;
	logic [15:0]        level;
	logic               result_load;
	logic               is_last;

	// intake
	assign item_stall = (state_q != ST_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign item_idx   = WW'(item.wheel);
	assign wheel_ok   = (32'(item.wheel) < NUM_WHEELS);

	// notch interval and speed numerator (distance * 1600)
	assign interval  = item.timestamp_us - prev_time_q[item_idx];
	assign notch_num = (NUM_W'(notch_q) << 10) + (NUM_W'(notch_q) << 9)
		+ (NUM_W'(notch_q) << 6);
	assign div_start = item_take && (item.kind == KIND_NOTCH) && wheel_ok
		&& seen_q[item_idx] && (interval != '0);

	dwps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (notch_num),
		.den    (interval),
		.done   (div_done),
		.quo    (div_quo)
	);

	// saturate quotient to the speed range
	assign quo_sat = (|div_quo[NUM_W-1:SPEED_W]) ? SPEED_MAX : div_quo[SPEED_W-1:0];

	// error terms of the current wheel
	assign pidx     = WW'(k_q);
	assign err      = {6'b0, target_q, 4'b0} - {2'b0, speed_q[pidx]};
	assign sum_wide = {{2{esum_q[pidx][SUM_W-1]}}, esum_q[pidx]}
		+ {{(SUM_W+2-ERR_W){err[ERR_W-1]}}, err};
	assign derr     = err - perr_q[pidx];

	// integral saturation at 32 bits
	always_comb begin
		if (sum_wide[SUM_W+1:SUM_W-1] == 3'b000 || sum_wide[SUM_W+1:SUM_W-1] == 3'b111) begin
			sum_sat = sum_wide[SUM_W-1:0];
		end else if (sum_wide[SUM_W+1]) begin
			sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
		end else begin
			sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
		end
	end

	assign mac_start = (state_q == ST_PID);
	assign mac_op    = '{gain_p: gain_p_q, gain_i: gain_i_q, gain_d: gain_d_q,
		err: err, esum: sum_sat, derr: derr};

	dwps_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.op     (mac_op),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	// level: floor shift, clamp to 0..65535
	always_comb begin
		if (mac_acc[ACC_W-1]) begin
			level = '0;
		end else if (|mac_acc[ACC_W-2:LVL_SH+16]) begin
			level = '1;
		end else begin
			level = mac_acc[LVL_SH+15:LVL_SH];
		end
	end

	assign is_last     = (k_q == 1'(NUM_OUT - 1));
	assign result_load = (state_q == ST_OUT) && (!result_valid_q || !result_stall);

	// control, registers and per-wheel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			target_q       <= TARGET_RST;
			notch_q        <= NOTCH_RST;
			gain_p_q       <= GAIN_P_RST;
			gain_i_q       <= GAIN_I_RST;
			gain_d_q       <= GAIN_D_RST;
			wsel_q         <= '0;
			k_q            <= 1'b0;
			result_valid_q <= 1'b0;
			for (int w = 0; w < NUM_WHEELS; w++) begin
				prev_time_q[w] <= '0;
				seen_q[w]      <= 1'b0;
				moved_q[w]     <= 1'b0;
				speed_q[w]     <= '0;
				esum_q[w]      <= '0;
				perr_q[w]      <= '0;
			end
		end else begin
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					REG_TARGET: target_q <= cfg_data[7:0];
					REG_NOTCH:  notch_q  <= cfg_data;
					REG_GAIN_P: gain_p_q <= cfg_data;
					REG_GAIN_I: gain_i_q <= cfg_data;
					REG_GAIN_D: gain_d_q <= cfg_data;
					default: ;
				endcase
			end

			// result register
			if (result_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						case (item.kind)
							KIND_NOTCH: begin
								if (wheel_ok) begin
									wsel_q                <= item_idx;
									seen_q[item_idx]      <= 1'b1;
									prev_time_q[item_idx] <= item.timestamp_us;
									if (seen_q[item_idx]) begin
										if (interval == '0) begin
											speed_q[item_idx] <= SPEED_MAX;
											moved_q[item_idx] <= 1'b1;
										end else begin
											state_q <= ST_DIV;
										end
									end
								end
							end
							KIND_STALL: begin
								for (int w = 0; w < NUM_WHEELS; w++) begin
									if (!moved_q[w]) begin
										speed_q[w] <= '0;
									end
									moved_q[w] <= 1'b0;
								end
							end
							KIND_PID: begin
								k_q     <= 1'b0;
								state_q <= ST_PID;
							end
							default: ;
						endcase
					end
				end
				ST_DIV: begin
					if (div_done) begin
						speed_q[wsel_q] <= quo_sat;
						moved_q[wsel_q] <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				ST_PID: begin
					esum_q[pidx] <= sum_sat;
					perr_q[pidx] <= err;
					state_q      <= ST_MAC;
				end
				ST_MAC: begin
					if (mac_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (result_load) begin
						if (is_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_PID;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_MAC && mac_done) begin
			lvl_q <= level;
		end
		if (result_load) begin
			result_q.out_wheel      <= k_q;
			result_q.drive_level    <= lvl_q;
			result_q.measured_speed <= speed_q[pidx];
			result_q.last           <= is_last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== src/dwps_div.sv =====
`default_nettype none

module dwps_div import dwps_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  num,
	input  wire logic [TIME_W-1:0] den,
	output logic                   done,
	output logic [NUM_W-1:0]       quo
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] den_q;
	logic [NUM_W-1:0]  nq_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [TIME_W:0]   trial;
	logic              ge;

	// one quotient bit per cycle, restoring
	assign trial = {rem_q, nq_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder and numerator / quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			nq_q  <= num;
		end else if (busy_q) begin
			rem_q <= ge ? TIME_W'(trial - {1'b0, den_q}) : trial[TIME_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = nq_q;

endmodule

`default_nettype wire

// ===== src/dwps_mac.sv =====
`default_nettype none

module dwps_mac import dwps_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire mac_op_t          op,
	output logic                  done,
	output logic [ACC_W-1:0]      acc
);

	localparam int CNT_W = $clog2(GAIN_W);

	logic [GAIN_W-1:0] gp_q, gi_q, gd_q;
	logic [ACC_W-1:0]  mp_q, mi_q, md_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [ACC_W-1:0]  pp_p, pp_i, pp_d;

	// partial products of the current gain bit
	assign pp_p = gp_q[0] ? mp_q : '0;
	assign pp_i = gi_q[0] ? mi_q : '0;
	assign pp_d = gd_q[0] ? md_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(GAIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// gains shift right, signed multiplicands shift left
	always_ff @(posedge clk) begin
		if (start) begin
			gp_q  <= op.gain_p;
			gi_q  <= op.gain_i;
			gd_q  <= op.gain_d;
			mp_q  <= {{(ACC_W-ERR_W){op.err[ERR_W-1]}}, op.err};
			mi_q  <= {{(ACC_W-SUM_W){op.esum[SUM_W-1]}}, op.esum};
			md_q  <= {{(ACC_W-ERR_W){op.derr[ERR_W-1]}}, op.derr};
			acc_q <= '0;
		end else if (busy_q) begin
			gp_q  <= gp_q >> 1;
			gi_q  <= gi_q >> 1;
			gd_q  <= gd_q >> 1;
			mp_q  <= mp_q << 1;
			mi_q  <= mi_q << 1;
			md_q  <= md_q << 1;
			acc_q <= acc_q + pp_p + pp_i + pp_d;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire
